[src/aes_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_pkg
// shared types, constants and byte functions for the aes-256 cbc encryptor
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int ROUNDS   = 14;
    localparam int NKEYS    = ROUNDS + 1;
    localparam int NW       = 4 * NKEYS;   // 32-bit expanded key words
    localparam int NW_BITS  = $clog2(NW + 1);
    localparam int RND_BITS = $clog2(NKEYS + 1);

    // register indexes
    localparam logic [2:0] REG_KEY0   = 3'd0;
    localparam logic [2:0] REG_KEY1   = 3'd1;
    localparam logic [2:0] REG_KEY2   = 3'd2;
    localparam logic [2:0] REG_KEY3   = 3'd3;
    localparam logic [2:0] REG_IV_LO  = 3'd4;
    localparam logic [2:0] REG_IV_HI  = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_ROUND,
        ST_OUT
    } state_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
        };
        return t[a];
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

endpackage

[src/aes_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module aes_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[src/aes_round.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_round
// one aes round: sub bytes, shift rows, optional mix columns, add round key
// ----------------------------------------------------------------------------
module aes_round (
    input  logic [127:0] state_in,
    input  logic [127:0] round_key,
    input  logic         do_mix,
    output logic [127:0] state_out
);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] m [16];
    logic [7:0] a0, a1, a2, a3, all;

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            s[i] = state_in[8*i +: 8];
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[r + 4*c] = aes_pkg::sbox(s[r + 4*((c + r) & 3)]);
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0  = t[4*c];
            a1  = t[4*c+1];
            a2  = t[4*c+2];
            a3  = t[4*c+3];
            all = a0 ^ a1 ^ a2 ^ a3;
            m[4*c]   = do_mix ? (a0 ^ all ^ aes_pkg::xt(a0 ^ a1)) : a0;
            m[4*c+1] = do_mix ? (a1 ^ all ^ aes_pkg::xt(a1 ^ a2)) : a1;
            m[4*c+2] = do_mix ? (a2 ^ all ^ aes_pkg::xt(a2 ^ a3)) : a2;
            m[4*c+3] = do_mix ? (a3 ^ all ^ aes_pkg::xt(a3 ^ a0)) : a3;
        end
        for (int i = 0; i < 16; i++) begin
            state_out[8*i +: 8] = m[i] ^ round_key[8*i +: 8];
        end
    end
endmodule

[src/aes256_cbc_encrypt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes256_cbc_encrypt
// aes-256 encryption in cbc mode with pkcs#7 padding of the final block
// ----------------------------------------------------------------------------
// channel   | direction | contents
// s_axis    | in        | plaintext block, first/final flags, tail byte count
// m_axis    | out       | ciphertext block, last flag
// apb       | in        | key words 0..3 and iv words at 8-byte spacing
//
// a block passes through load, 14 rounds on one shared round unit and a read
// ahead of the key ram, then the output transaction; a first block adds key
// expansion before that, one 32-bit key word per cycle into the ram.
// reset clears control state and the chaining value; round keys are
// undefined until a first block expands them. s_tready is low from
// acceptance until the result transaction completes.
// ----------------------------------------------------------------------------
module aes256_cbc_encrypt (
    input  logic         aclk,
    input  logic         aresetn,
    // apb
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [5:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,   // plain_low, plain_high, tail_bytes, pad
    input  logic [1:0]   s_tuser,   // first_block, final_block
    // output stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // cipher_low, cipher_high
    output logic         m_tlast
);
    // configuration registers
    logic [63:0] cfg_reg [6];
    logic [2:0]  cfg_idx;
    assign cfg_idx = paddr[5:3];
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) cfg_reg[i] <= '0;
        end else if (psel && penable && pwrite) begin
            if (cfg_idx <= aes_pkg::REG_IV_HI) begin
                cfg_reg[cfg_idx] <= pwdata;
            end
        end
    end

    always_comb begin
        unique case (cfg_idx)
            aes_pkg::REG_KEY0:  prdata = cfg_reg[0];
            aes_pkg::REG_KEY1:  prdata = cfg_reg[1];
            aes_pkg::REG_KEY2:  prdata = cfg_reg[2];
            aes_pkg::REG_KEY3:  prdata = cfg_reg[3];
            aes_pkg::REG_IV_LO: prdata = cfg_reg[4];
            aes_pkg::REG_IV_HI: prdata = cfg_reg[5];
            default:            prdata = '0;
        endcase
    end

    // control
    aes_pkg::state_t state_reg, state_next;
    logic [aes_pkg::NW_BITS-1:0]  kidx_reg, kidx_next;   // expansion word index
    logic [aes_pkg::RND_BITS-1:0] rnd_reg, rnd_next;     // round counter
    logic [7:0]   rc_reg, rc_next;
    logic         last_reg, last_next;
    logic [127:0] chain_reg, chain_next;
    logic [127:0] st_reg, st_next;
    logic [127:0] plain_reg, plain_next;

    // last eight expanded words kept in a shift window
    logic [31:0] win_reg [8];
    logic [31:0] win_next [8];

    // round key ram: 32-bit words, four per round key, one round key read per cycle
    // key words read as 128 bits by four lanes of rams, one per column
    logic       kr_we [4];
    logic [3:0] kr_waddr;
    logic [31:0] kr_wdata;
    logic [3:0] kr_raddr;
    logic [31:0] kr_rdata [4];
    logic [127:0] rkey;

    genvar g;
    generate
        for (g = 0; g < 4; g++) begin : g_kram
            aes_ram #(.WIDTH(32), .DEPTH(16)) u_ram (
                .aclk (aclk),
                .we   (kr_we[g]),
                .waddr(kr_waddr),
                .wdata(kr_wdata),
                .raddr(kr_raddr),
                .rdata(kr_rdata[g])
            );
            assign rkey[32*g +: 32] = kr_rdata[g];
        end
    endgenerate

    // new expanded word
    logic [31:0] prev, tw, neww;
    always_comb begin
        prev = win_reg[7];
        tw   = prev;
        if (kidx_reg[2:0] == 3'd0) begin
            tw = {aes_pkg::sbox(prev[7:0]),  aes_pkg::sbox(prev[31:24]),
                  aes_pkg::sbox(prev[23:16]), aes_pkg::sbox(prev[15:8]) ^ rc_reg};
        end else if (kidx_reg[2:0] == 3'd4) begin
            tw = {aes_pkg::sbox(prev[31:24]), aes_pkg::sbox(prev[23:16]),
                  aes_pkg::sbox(prev[15:8]),  aes_pkg::sbox(prev[7:0])};
        end
        neww = win_reg[0] ^ tw;
    end

    logic [127:0] rnd_out;
    aes_round u_round (
        .state_in (st_reg),
        .round_key(rkey),
        .do_mix   (rnd_reg != aes_pkg::RND_BITS'(aes_pkg::ROUNDS)),
        .state_out(rnd_out)
    );

    // padded plaintext of the incoming transaction
    logic [127:0] pad_in;
    logic [3:0]   tail;
    always_comb begin
        tail   = s_tdata[131:128];
        pad_in = s_tdata[127:0];
        if (s_tuser[1]) begin
            for (int i = 0; i < 16; i++) begin
                if (4'(i) >= tail) pad_in[8*i +: 8] = 8'd16 - {4'd0, tail};
            end
        end
    end

    assign s_tready = (state_reg == aes_pkg::ST_IDLE);
    assign m_tvalid = (state_reg == aes_pkg::ST_OUT);
    assign m_tdata  = chain_reg;
    assign m_tlast  = last_reg;

    always_comb begin
        state_next = state_reg;
        kidx_next  = kidx_reg;
        rnd_next   = rnd_reg;
        rc_next    = rc_reg;
        last_next  = last_reg;
        chain_next = chain_reg;
        st_next    = st_reg;
        plain_next = plain_reg;
        for (int i = 0; i < 8; i++) win_next[i] = win_reg[i];
        for (int i = 0; i < 4; i++) kr_we[i] = 1'b0;
        kr_waddr = '0;
        kr_wdata = '0;
        kr_raddr = '0;
        unique case (state_reg)
            aes_pkg::ST_IDLE: begin
                kr_raddr = '0;
                if (s_tvalid) begin
                    last_next  = s_tuser[1];
                    plain_next = pad_in;
                    if (s_tuser[0]) begin
                        // seed window with key, write words 0..7 during expansion
                        for (int i = 0; i < 4; i++) begin
                            win_next[2*i]   = cfg_reg[i][31:0];
                            win_next[2*i+1] = cfg_reg[i][63:32];
                        end
                        chain_next = {cfg_reg[5], cfg_reg[4]};
                        kidx_next  = '0;
                        rc_next    = 8'h01;
                        state_next = aes_pkg::ST_EXPAND;
                    end else begin
                        st_next    = pad_in ^ chain_reg;
                        rnd_next   = '0;
                        state_next = aes_pkg::ST_ROUND;
                    end
                end
            end
            aes_pkg::ST_EXPAND: begin
                // words 0..7 come from the window head, later ones are computed
                kr_waddr = kidx_reg[5:2];
                if (kidx_reg < aes_pkg::NW_BITS'(8)) begin
                    kr_wdata = win_reg[0];
                    for (int i = 0; i < 7; i++) win_next[i] = win_reg[i+1];
                    win_next[7] = win_reg[0];
                end else begin
                    kr_wdata = neww;
                    for (int i = 0; i < 7; i++) win_next[i] = win_reg[i+1];
                    win_next[7] = neww;
                    if (kidx_reg[2:0] == 3'd0) rc_next = aes_pkg::xt(rc_reg);
                end
                kr_we[kidx_reg[1:0]] = 1'b1;
                kidx_next = kidx_reg + 1'b1;
                kr_raddr  = '0;
                if (kidx_reg == aes_pkg::NW_BITS'(aes_pkg::NW - 1)) begin
                    st_next    = plain_reg ^ chain_reg;
                    rnd_next   = '0;
                    state_next = aes_pkg::ST_ROUND;
                end
            end
            aes_pkg::ST_ROUND: begin
                // rnd 0 adds round key 0; rnd r>=1 applies round r
                kr_raddr = rnd_reg + 1'b1;
                if (rnd_reg == '0) begin
                    st_next = st_reg ^ rkey;
                    rnd_next = rnd_reg + 1'b1;
                end else begin
                    st_next = rnd_out;
                    if (rnd_reg == aes_pkg::RND_BITS'(aes_pkg::ROUNDS)) begin
                        chain_next = rnd_out;
                        state_next = aes_pkg::ST_OUT;
                    end else begin
                        rnd_next = rnd_reg + 1'b1;
                    end
                end
            end
            aes_pkg::ST_OUT: begin
                if (m_tready) state_next = aes_pkg::ST_IDLE;
            end
            default: state_next = aes_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= aes_pkg::ST_IDLE;
            chain_reg <= '0;
            kidx_reg  <= '0;
            rnd_reg   <= '0;
            rc_reg    <= 8'h01;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            chain_reg <= chain_next;
            kidx_reg  <= kidx_next;
            rnd_reg   <= rnd_next;
            rc_reg    <= rc_next;
            last_reg  <= last_next;
        end
        st_reg    <= st_next;
        plain_reg <= plain_next;
        for (int i = 0; i < 8; i++) win_reg[i] <= win_next[i];
    end
endmodule
